[hdl/spq_pkg.sv]
// spq_pkg: shared constants, controller states and command struct
// for the sorted priority queue unit; no dependencies
`default_nettype none

package spq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} spq_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} spq_cmd_t;

endpackage

`default_nettype wire

[hdl/spq_datapath.sv]
// spq_datapath: operand registers and sorted compare-and-shift entry array
// depends on spq_pkg
`default_nettype none

module spq_datapath
	import spq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire spq_cmd_t                 cmd,
	input  wire logic                     mode,
	input  wire logic signed [DATA_W-1:0] data_value,
	input  wire logic signed [DATA_W-1:0] priority_key,
	output logic signed [DATA_W-1:0]      head_data,
	output logic signed [DATA_W-1:0]      head_priority,
	output logic                          is_empty,
	output logic [CNT_W-1:0]              entry_count,
	output logic                          dropped
);

	logic                     mode_q;
	logic signed [DATA_W-1:0] dval_q;
	logic signed [DATA_W-1:0] key_q;
	logic signed [DATA_W-1:0] data_q [DEPTH];
	logic signed [DATA_W-1:0] prio_q [DEPTH];
	logic signed [DATA_W-1:0] data_d [DEPTH];
	logic signed [DATA_W-1:0] prio_d [DEPTH];
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_d;
	logic                     drop_q;
	logic                     drop_d;
	logic [DEPTH-1:0]         stay;
	logic                     full;

	// operand capture on transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			dval_q <= data_value;
			key_q  <= priority_key;
		end
	end

	// per-cell compare: entry stays when held and its priority is not above the key
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			stay[i] = (CNT_W'(i) < count_q) && (prio_q[i] <= key_q);
		end
	end

	assign full = (count_q == CNT_W'(DEPTH));

	// next state of the array: insert shifts up past the slot, remove shifts down
	always_comb begin
		count_d = count_q;
		drop_d  = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			data_d[i] = data_q[i];
			prio_d[i] = prio_q[i];
		end
		if (mode_q == MODE_INSERT) begin
			if (full) begin
				drop_d = 1'b1;
			end else begin
				count_d = count_q + 1'b1;
				if (!stay[0]) begin
					data_d[0] = dval_q;
					prio_d[0] = key_q;
				end
				for (int i = 1; i < DEPTH; i++) begin
					if (!stay[i]) begin
						if (stay[i-1]) begin
							data_d[i] = dval_q;
							prio_d[i] = key_q;
						end else begin
							data_d[i] = data_q[i-1];
							prio_d[i] = prio_q[i-1];
						end
					end
				end
			end
		end else if (count_q != '0) begin
			count_d = count_q - 1'b1;
			for (int i = 0; i < DEPTH - 1; i++) begin
				data_d[i] = data_q[i+1];
				prio_d[i] = prio_q[i+1];
			end
		end
	end

	// entry array, no reset: only entries below the count are ever shown
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				data_q[i] <= data_d[i];
				prio_q[i] <= prio_d[i];
			end
		end
	end

	// count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.exec) begin
			count_q <= count_d;
			drop_q  <= drop_d;
		end
	end

	// result fields straight from state
	assign is_empty      = (count_q == '0);
	assign head_data     = is_empty ? '0 : data_q[0];
	assign head_priority = is_empty ? '0 : prio_q[0];
	assign entry_count   = count_q;
	assign dropped       = drop_q;

endmodule

`default_nettype wire

[hdl/spq_ctrl.sv]
// spq_ctrl: two-state controller sequencing operand capture, execute and result strobe
// depends on spq_pkg
`default_nettype none

module spq_ctrl
	import spq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output spq_cmd_t  cmd
);

	spq_state_t state_q;
	spq_state_t state_d;
	logic       done_q;

	// state register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		busy     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

`default_nettype wire

[hdl/sorted_priority_queue_unit.sv]
// sorted_priority_queue_unit: top level of the min-first sorted priority queue
// depends on spq_pkg, spq_ctrl, spq_datapath
//
// channel   signals                                          direction  timing
// command   start, busy, mode, data_value, priority_key      in         transfer on start && !busy
// result    done, head_data, head_priority, is_empty,        out        one-cycle strobe on done
//           entry_count, dropped
//
// each item has operand capture at the transfer edge, then the execute state, in
// which all sixteen cells compare against the key and shift in parallel.
// done rises the cycle after that; a new start is taken in that same cycle.
// reset clears the count, drop flag and controller only; no clearing pass is needed.
// the result receiver cannot stall; fields hold until the next item executes.
`default_nettype none

module sorted_priority_queue_unit
	import spq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     mode,
	input  wire logic signed [DATA_W-1:0] data_value,
	input  wire logic signed [DATA_W-1:0] priority_key,
	output logic                          done,
	output logic signed [DATA_W-1:0]      head_data,
	output logic signed [DATA_W-1:0]      head_priority,
	output logic                          is_empty,
	output logic [CNT_W-1:0]              entry_count,
	output logic                          dropped
);

	spq_cmd_t cmd;

	// sequencing
	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// entry storage and compare-and-shift
	spq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.data_value    (data_value),
		.priority_key  (priority_key),
		.head_data     (head_data),
		.head_priority (head_priority),
		.is_empty      (is_empty),
		.entry_count   (entry_count),
		.dropped       (dropped)
	);

endmodule

`default_nettype wire

[hdl/spq_checker.sv]
// spq_checker: port-level assertions for sorted_priority_queue_unit, bound to the top level
// depends on spq_pkg and sorted_priority_queue_unit
`default_nettype none

module spq_checker
	import spq_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic                     mode,
	input wire logic                     done,
	input wire logic                     is_empty,
	input wire logic [CNT_W-1:0]         entry_count,
	input wire logic                     dropped
);

	// every transfer gets its result strobe once ST_EXEC has passed and done_q has registered it
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result strobe missing after transfer");

	// a result only shows while idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// empty flag agrees with count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	// a drop only happens on a full queue and never beyond capacity
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((!dropped || entry_count == CNT_W'(DEPTH)) && entry_count <= CNT_W'(DEPTH)))
		else $error("drop flagged on a queue that is not full");

	// a remove transferred while a result strobe shows never raises the count
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_REMOVE && done) |=> ##1 (entry_count <= $past(entry_count, 2)))
		else $error("remove raised the count");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.mode        (mode),
	.done        (done),
	.is_empty    (is_empty),
	.entry_count (entry_count),
	.dropped     (dropped)
);

`default_nettype wire

[bench/sorted_priority_queue_unit_tb.sv]
// sorted_priority_queue_unit_tb: self-checking bench for the min-first sorted priority queue
// runs directed and random insert/remove traffic against an internal queue predictor
// depends on spq_pkg and sorted_priority_queue_unit
`timescale 1ns / 100ps

module sorted_priority_queue_unit_tb;
	import spq_pkg::*;

	localparam int RANDOM_ITEMS = 1450;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_LIMIT = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	localparam logic signed [DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] PRIO_MAX = 32'sh7fff_ffff;

	// head view after one queue operation
	typedef struct packed {
		logic signed [DATA_W-1:0] head_data;
		logic signed [DATA_W-1:0] head_priority;
		logic                     is_empty;
		logic [CNT_W-1:0]         entry_count;
		logic                     dropped;
	} head_report_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     mode = MODE_INSERT;
	logic signed [DATA_W-1:0] data_value = '0;
	logic signed [DATA_W-1:0] priority_key = '0;
	wire logic                busy;
	wire logic                done;
	wire logic signed [DATA_W-1:0] head_data;
	wire logic signed [DATA_W-1:0] head_priority;
	wire logic                is_empty;
	wire logic [CNT_W-1:0]    entry_count;
	wire logic                dropped;

	// predicted queue contents, sorted by ascending priority
	logic signed [DATA_W-1:0] queue_data [DEPTH];
	logic signed [DATA_W-1:0] queue_prio [DEPTH];
	int                       queue_fill = 0;

	head_report_t pending_heads[$];

	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int n_inserts = 0;
	int n_removes = 0;
	int n_drops = 0;
	int n_empty_removes = 0;
	int n_full_hits = 0;
	int n_results = 0;

	sorted_priority_queue_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.data_value    (data_value),
		.priority_key  (priority_key),
		.done          (done),
		.head_data     (head_data),
		.head_priority (head_priority),
		.is_empty      (is_empty),
		.entry_count   (entry_count),
		.dropped       (dropped)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_heads.size());
			$display("status: fail");
			$finish;
		end
	end

	// apply one operation to the predicted queue and return the new head view
	function automatic head_report_t apply_queue_op(input logic op,
		input logic signed [DATA_W-1:0] dval, input logic signed [DATA_W-1:0] pkey);
		head_report_t rep;
		int pos;
		int i;
		rep = '0;
		if (op == MODE_INSERT) begin
			if (queue_fill >= DEPTH) begin
				rep.dropped = 1'b1;
			end else begin
				// equal priorities stay ahead of the new entry
				pos = 0;
				while (pos < queue_fill && queue_prio[pos] <= pkey)
					pos++;
				for (i = queue_fill; i > pos; i--) begin
					queue_data[i] = queue_data[i-1];
					queue_prio[i] = queue_prio[i-1];
				end
				queue_data[pos] = dval;
				queue_prio[pos] = pkey;
				queue_fill++;
			end
		end else if (queue_fill > 0) begin
			for (i = 0; i + 1 < queue_fill; i++) begin
				queue_data[i] = queue_data[i+1];
				queue_prio[i] = queue_prio[i+1];
			end
			queue_fill--;
		end
		if (queue_fill > 0) begin
			rep.head_data = queue_data[0];
			rep.head_priority = queue_prio[0];
		end else begin
			rep.is_empty = 1'b1;
		end
		rep.entry_count = CNT_W'(queue_fill);
		return rep;
	endfunction

	// priority mix: small range for ties, full range, and the signed extremes
	function automatic logic signed [DATA_W-1:0] pick_priority();
		int v;
		v = $urandom_range(0, 8);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return DATA_W'(v - 4);
			4, 5, 6: return $urandom;
			7: return ($urandom_range(0, 1) == 0) ? PRIO_MIN : PRIO_MAX;
			8: return PRIO_MIN + DATA_W'(v);
			default: return PRIO_MAX - DATA_W'(v);
		endcase
	endfunction

	// one command transfer; start is left high so a following item can go back to back
	task automatic send_item(input logic op, input logic signed [DATA_W-1:0] dval,
		input logic signed [DATA_W-1:0] pkey);
		head_report_t rep;
		start <= 1'b1;
		mode <= op;
		data_value <= dval;
		priority_key <= pkey;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (op == MODE_INSERT) begin
			n_inserts++;
			if (queue_fill >= DEPTH)
				n_full_hits++;
		end else begin
			n_removes++;
			if (queue_fill == 0)
				n_empty_removes++;
		end
		rep = apply_queue_op(op, dval, pkey);
		if (rep.dropped)
			n_drops++;
		pending_heads = {pending_heads, rep};
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender bursts with random gaps, some long stretches without idling
	task automatic next_gap();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			pause_sender($urandom_range(1, 12));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 6);
		end
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
		input logic [DATA_W-1:0] act_val);
		if (exp_val !== act_val) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on %s at cycle %0d: expected %h, got %h",
					name, cycle_count, exp_val, act_val);
		end
	endtask

	// result checker against the oldest outstanding expectation
	always @(posedge clk) begin
		head_report_t exp_rep;
		if (arst_n && done === 1'b1) begin
			n_results++;
			if (pending_heads.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result at cycle %0d: head %h/%h count %0d",
						cycle_count, head_data, head_priority, entry_count);
			end else begin
				exp_rep = pending_heads.pop_front();
				check_field("head_data", exp_rep.head_data, head_data);
				check_field("head_priority", exp_rep.head_priority, head_priority);
				check_field("is_empty", exp_rep.is_empty, is_empty);
				check_field("entry_count", exp_rep.entry_count, entry_count);
				check_field("dropped", exp_rep.dropped, dropped);
			end
		end
	end

	// remove on an empty queue leaves it empty with a zero head
	task automatic test_remove_on_empty();
		send_item(MODE_REMOVE, PRIO_MAX, PRIO_MIN);
		next_gap();
	endtask

	// signed extremes of data and priority, then drain to empty
	task automatic test_field_extremes();
		send_item(MODE_INSERT, PRIO_MAX, PRIO_MAX);
		next_gap();
		send_item(MODE_INSERT, PRIO_MIN, PRIO_MIN);
		next_gap();
		send_item(MODE_INSERT, '0, '0);
		next_gap();
		send_item(MODE_INSERT, -1, -1);
		next_gap();
		repeat (4) begin
			send_item(MODE_REMOVE, $urandom, $urandom);
			next_gap();
		end
	endtask

	// equal priorities keep arrival order; fill to capacity and hit the full case
	task automatic test_ties_and_full();
		int i;
		for (i = 0; i < DEPTH; i++) begin
			send_item(MODE_INSERT, DATA_W'(i + 1), DATA_W'((i % 3) * 5 - 5));
			next_gap();
		end
		send_item(MODE_INSERT, 32'shdead_beef, PRIO_MIN);
		next_gap();
	endtask

	// random traffic in rounds biased toward filling, draining or balanced
	task automatic test_random_traffic();
		int sent;
		int round_len;
		int insert_pct;
		logic op;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0: insert_pct = 85;
				1: insert_pct = 15;
				default: insert_pct = 50;
			endcase
			round_len = $urandom_range(8, 48);
			repeat (round_len) begin
				op = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
				sent++;
				send_item(op, $urandom, pick_priority());
				next_gap();
			end
		end
	endtask

	initial begin
		int waited;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_remove_on_empty();
		test_field_extremes();
		test_ties_and_full();
		test_random_traffic();

		// let outstanding results arrive
		start <= 1'b0;
		waited = 0;
		while (pending_heads.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_heads.size() != 0) begin
			$display("%0d expected results never arrived", pending_heads.size());
			mismatches += pending_heads.size();
		end

		$display("covered %0d inserts (%0d refused at full) and %0d removes (%0d on empty)",
			n_inserts, n_drops, n_removes, n_empty_removes);
		$display("%0d results checked, %0d mismatches", n_results, mismatches);
		if (mismatches == 0 && n_full_hits == n_drops)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
hdl/spq_pkg.sv
hdl/spq_datapath.sv
hdl/spq_ctrl.sv
hdl/sorted_priority_queue_unit.sv
hdl/spq_checker.sv
bench/sorted_priority_queue_unit_tb.sv
